// File: rtl/core/som_bmu_pkg.sv
// ----------------------------------------------------------------------------
// som_bmu_pkg
// Shared constants, register codes and inter-module types of the SOM
// best-matching-unit search block.
// ----------------------------------------------------------------------------
package som_bmu_pkg;

   // Fixed payload widths of the channels
   localparam int unsigned NODE_W    = 4;
   localparam int unsigned DIM_IDX_W = 5;
   localparam int unsigned ELEM_W    = 16;
   localparam int unsigned DIST_W    = 37;

   // Node coordinates inside the pipeline (covers maps up to 256 x 256)
   localparam int unsigned COORD_W = 8;

   localparam logic [DIST_W-1:0] DIST_MAX = '1;

   // Input item actions
   localparam logic ACTION_CODEBOOK = 1'b0;
   localparam logic ACTION_FEATURE  = 1'b1;

   // Control and status register port
   localparam int unsigned CSR_AW      = 4;
   localparam int unsigned CSR_DW      = 32;
   localparam int unsigned MAP_REG_W   = 5;
   localparam int unsigned DIMS_REG_W  = 6;

   typedef logic [1:0] reg_index_type;
   localparam reg_index_type REG_MAP_WIDTH   = 2'd0;
   localparam reg_index_type REG_MAP_HEIGHT  = 2'd1;
   localparam reg_index_type REG_VECTOR_DIMS = 2'd2;

   localparam logic [MAP_REG_W-1:0]  RESET_MAP_WIDTH   = 5'd16;
   localparam logic [MAP_REG_W-1:0]  RESET_MAP_HEIGHT  = 5'd16;
   localparam logic [DIMS_REG_W-1:0] RESET_VECTOR_DIMS = 6'd32;

   // Position of one element read within the scan
   typedef struct packed {
      logic               first_dim;
      logic               last_dim;
      logic               first_node;
      logic               last_node;
      logic [COORD_W-1:0] x;
      logic [COORD_W-1:0] y;
   } tag_type;

   typedef struct packed {
      logic    valid;
      tag_type tag;
   } issue_type;

   // Sequencer status toward the top level
   typedef struct packed {
      logic ready;
      logic load;
   } seq_status_type;

   // Winner reported by the distance unit
   typedef struct packed {
      logic               done;
      logic [COORD_W-1:0] x;
      logic [COORD_W-1:0] y;
      logic [DIST_W-1:0]  dist_sq;
   } result_type;

   // Saturate a register value to the range 1..hi
   function automatic int unsigned clamp_count(int unsigned v, int unsigned hi);
      int unsigned r;
      if (v < 1) begin
         r = 1;
      end else if (v > hi) begin
         r = hi;
      end else begin
         r = v;
      end
      return r;
   endfunction

endpackage

// File: rtl/core/som_bmu_if.sv
// ----------------------------------------------------------------------------
// som_bmu_if
// Valid/ready channel interfaces for the input items and the search results.
// ----------------------------------------------------------------------------
interface som_bmu_req_if;
   logic                                   valid;
   logic                                   ready;
   logic                                   action;
   logic [som_bmu_pkg::NODE_W-1:0]         node_x;
   logic [som_bmu_pkg::NODE_W-1:0]         node_y;
   logic [som_bmu_pkg::DIM_IDX_W-1:0]      dim_index;
   logic signed [som_bmu_pkg::ELEM_W-1:0]  elem_value;
   logic                                   last_elem;

   modport source (
      output valid, action, node_x, node_y, dim_index, elem_value, last_elem,
      input  ready
   );
   modport sink (
      input  valid, action, node_x, node_y, dim_index, elem_value, last_elem,
      output ready
   );
endinterface

interface som_bmu_rsp_if;
   logic                              valid;
   logic                              ready;
   logic [som_bmu_pkg::NODE_W-1:0]    bmu_x;
   logic [som_bmu_pkg::NODE_W-1:0]    bmu_y;
   logic [som_bmu_pkg::DIST_W-1:0]    best_dist_sq;

   modport source (output valid, bmu_x, bmu_y, best_dist_sq, input ready);
   modport sink   (input  valid, bmu_x, bmu_y, best_dist_sq, output ready);
endinterface

// File: rtl/core/som_bmu_csr.sv
// ----------------------------------------------------------------------------
// som_bmu_csr
// Configuration registers behind an APB-style port: map size and dimensions.
// ----------------------------------------------------------------------------
module som_bmu_csr (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  psel,
   input  logic                                  penable,
   input  logic                                  pwrite,
   input  logic [som_bmu_pkg::CSR_AW-1:0]        paddr,
   input  logic [som_bmu_pkg::CSR_DW-1:0]        pwdata,
   output logic [som_bmu_pkg::CSR_DW-1:0]        prdata,
   output logic                                  pready,
   output logic [som_bmu_pkg::MAP_REG_W-1:0]     map_width,
   output logic [som_bmu_pkg::MAP_REG_W-1:0]     map_height,
   output logic [som_bmu_pkg::DIMS_REG_W-1:0]    vector_dims
);
   import som_bmu_pkg::*;

   logic [MAP_REG_W-1:0]  map_width_ff;
   logic [MAP_REG_W-1:0]  map_height_ff;
   logic [DIMS_REG_W-1:0] vector_dims_ff;
   reg_index_type         reg_index;
   logic                  wr_en;

   assign pready    = 1'b1;
   assign reg_index = paddr[CSR_AW-1:2];
   assign wr_en     = psel & penable & pwrite;

   // Write on the access phase; unknown indexes drop the transfer
   always_ff @(posedge clock) begin
      if (reset) begin
         map_width_ff   <= RESET_MAP_WIDTH;
         map_height_ff  <= RESET_MAP_HEIGHT;
         vector_dims_ff <= RESET_VECTOR_DIMS;
      end else if (wr_en) begin
         unique case (reg_index)
            REG_MAP_WIDTH:   map_width_ff   <= pwdata[MAP_REG_W-1:0];
            REG_MAP_HEIGHT:  map_height_ff  <= pwdata[MAP_REG_W-1:0];
            REG_VECTOR_DIMS: vector_dims_ff <= pwdata[DIMS_REG_W-1:0];
            default: ;
         endcase
      end
   end

   // Read back
   always_comb begin
      unique case (reg_index)
         REG_MAP_WIDTH:   prdata = CSR_DW'(map_width_ff);
         REG_MAP_HEIGHT:  prdata = CSR_DW'(map_height_ff);
         REG_VECTOR_DIMS: prdata = CSR_DW'(vector_dims_ff);
         default:         prdata = '0;
      endcase
   end

   assign map_width   = map_width_ff;
   assign map_height  = map_height_ff;
   assign vector_dims = vector_dims_ff;

endmodule

// File: rtl/core/som_bmu_mem.sv
// ----------------------------------------------------------------------------
// som_bmu_mem
// Codebook store and feature buffer: one write and one registered read each.
// ----------------------------------------------------------------------------
module som_bmu_mem #(
   parameter int unsigned MAX_MAP_X  = 16,
   parameter int unsigned MAX_MAP_Y  = 16,
   parameter int unsigned MAX_DIMS   = 32,
   parameter int unsigned VALUE_BITS = 16,
   localparam int unsigned CB_DEPTH  = MAX_MAP_X * MAX_MAP_Y * MAX_DIMS,
   localparam int unsigned CB_AW     = (CB_DEPTH > 1) ? $clog2(CB_DEPTH) : 1,
   localparam int unsigned DW        = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1
) (
   input  logic                         clock,
   input  logic                         cb_we,
   input  logic [CB_AW-1:0]             cb_waddr,
   input  logic                         fb_we,
   input  logic [DW-1:0]                fb_waddr,
   input  logic [VALUE_BITS-1:0]        wdata,
   input  logic                         rd_en,
   input  logic [CB_AW-1:0]             cb_raddr,
   input  logic [DW-1:0]                fb_raddr,
   output logic signed [VALUE_BITS-1:0] cb_rdata,
   output logic signed [VALUE_BITS-1:0] fb_rdata
);
   logic [VALUE_BITS-1:0] codebook_ff [CB_DEPTH];
   logic [VALUE_BITS-1:0] feature_ff  [MAX_DIMS];
   logic [VALUE_BITS-1:0] cb_rdata_ff;
   logic [VALUE_BITS-1:0] fb_rdata_ff;

   // Codebook port
   always_ff @(posedge clock) begin
      if (cb_we) begin
         codebook_ff[cb_waddr] <= wdata;
      end
      if (rd_en) begin
         cb_rdata_ff <= codebook_ff[cb_raddr];
      end
   end

   // Feature port
   always_ff @(posedge clock) begin
      if (fb_we) begin
         feature_ff[fb_waddr] <= wdata;
      end
      if (rd_en) begin
         fb_rdata_ff <= feature_ff[fb_raddr];
      end
   end

   assign cb_rdata = signed'(cb_rdata_ff);
   assign fb_rdata = signed'(fb_rdata_ff);

endmodule

// File: rtl/core/som_bmu_seq.sv
// ----------------------------------------------------------------------------
// som_bmu_seq
// Scan sequencer: walks rows, columns and dimensions, one element read per
// cycle, then waits for the winner and posts it to the result register.
// ----------------------------------------------------------------------------
module som_bmu_seq #(
   parameter int unsigned MAX_MAP_X = 16,
   parameter int unsigned MAX_MAP_Y = 16,
   parameter int unsigned MAX_DIMS  = 32,
   localparam int unsigned CB_DEPTH = MAX_MAP_X * MAX_MAP_Y * MAX_DIMS,
   localparam int unsigned CB_AW    = (CB_DEPTH > 1) ? $clog2(CB_DEPTH) : 1,
   localparam int unsigned XW       = (MAX_MAP_X > 1) ? $clog2(MAX_MAP_X) : 1,
   localparam int unsigned YW       = (MAX_MAP_Y > 1) ? $clog2(MAX_MAP_Y) : 1,
   localparam int unsigned DW       = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   input  logic                                done,
   input  logic                                rsp_free,
   input  logic [som_bmu_pkg::MAP_REG_W-1:0]   map_width,
   input  logic [som_bmu_pkg::MAP_REG_W-1:0]   map_height,
   input  logic [som_bmu_pkg::DIMS_REG_W-1:0]  vector_dims,
   output som_bmu_pkg::issue_type              issue,
   output logic [CB_AW-1:0]                    cb_raddr,
   output logic [DW-1:0]                       fb_raddr,
   output som_bmu_pkg::seq_status_type         status
);
   import som_bmu_pkg::*;

   typedef enum logic [1:0] {IDLE, SCAN, WAIT, HOLD} state_type;

   state_type     state_ff;
   logic [XW-1:0] x_ff, x_last_ff;
   logic [YW-1:0] y_ff, y_last_ff;
   logic [DW-1:0] d_ff, d_last_ff;
   logic          x_end, y_end, d_end;

   assign x_end = (x_ff == x_last_ff);
   assign y_end = (y_ff == y_last_ff);
   assign d_end = (d_ff == d_last_ff);

   // Hold state, limits and scan counters
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= IDLE;
      end else begin
         unique case (state_ff)
            IDLE: begin
               if (start) begin
                  x_last_ff <= XW'(clamp_count(32'(map_width), MAX_MAP_X) - 1);
                  y_last_ff <= YW'(clamp_count(32'(map_height), MAX_MAP_Y) - 1);
                  d_last_ff <= DW'(clamp_count(32'(vector_dims), MAX_DIMS) - 1);
                  x_ff      <= '0;
                  y_ff      <= '0;
                  d_ff      <= '0;
                  state_ff  <= SCAN;
               end
            end
            SCAN: begin
               if (d_end) begin
                  d_ff <= '0;
                  if (x_end) begin
                     x_ff <= '0;
                     if (y_end) begin
                        state_ff <= WAIT;
                     end else begin
                        y_ff <= y_ff + 1'b1;
                     end
                  end else begin
                     x_ff <= x_ff + 1'b1;
                  end
               end else begin
                  d_ff <= d_ff + 1'b1;
               end
            end
            WAIT: begin
               if (done) begin
                  state_ff <= HOLD;
               end
            end
            HOLD: begin
               if (rsp_free) begin
                  state_ff <= IDLE;
               end
            end
            default: state_ff <= IDLE;
         endcase
      end
   end

   // Issue one element read per scan cycle
   assign issue.valid          = (state_ff == SCAN);
   assign issue.tag.first_dim  = (d_ff == '0);
   assign issue.tag.last_dim   = d_end;
   assign issue.tag.first_node = (x_ff == '0) && (y_ff == '0);
   assign issue.tag.last_node  = x_end && y_end;
   assign issue.tag.x          = COORD_W'(x_ff);
   assign issue.tag.y          = COORD_W'(y_ff);

   assign cb_raddr = CB_AW'((32'(y_ff) * MAX_MAP_X + 32'(x_ff)) * MAX_DIMS + 32'(d_ff));
   assign fb_raddr = d_ff;

   assign status.ready = (state_ff == IDLE);
   assign status.load  = (state_ff == HOLD) && rsp_free;

`ifndef NO_ASSERTIONS
   a_start_blocks: assert property (@(posedge clock) disable iff (reset)
      start |=> !status.ready)
      else $error("sequencer still ready after a search start");
   a_done_when_waiting: assert property (@(posedge clock) disable iff (reset)
      done |-> (state_ff == WAIT))
      else $error("winner reported outside the wait state");
`endif

endmodule

// File: rtl/core/som_bmu_dist.sv
// ----------------------------------------------------------------------------
// som_bmu_dist
// Shared distance unit: subtract, square and accumulate one element per
// cycle, then compare each node total against the best so far.
// ----------------------------------------------------------------------------
module som_bmu_dist #(
   parameter int unsigned VALUE_BITS = 16,
   localparam int unsigned DIFF_W    = VALUE_BITS + 1,
   localparam int unsigned SQ_W      = 2 * DIFF_W,
   localparam int unsigned SUM_W     =
      ((SQ_W > som_bmu_pkg::DIST_W) ? SQ_W : som_bmu_pkg::DIST_W) + 1
) (
   input  logic                         clock,
   input  logic                         reset,
   input  som_bmu_pkg::issue_type       issue,
   input  logic signed [VALUE_BITS-1:0] cb_rdata,
   input  logic signed [VALUE_BITS-1:0] fb_rdata,
   output som_bmu_pkg::result_type      result
);
   import som_bmu_pkg::*;

   issue_type                 tag1_ff, tag2_ff, tag3_ff;
   logic                      node_vld_ff;
   tag_type                   node_tag_ff;
   logic                      done_ff;
   logic signed [DIFF_W-1:0]  diff_ff;
   logic signed [SQ_W-1:0]    prod;
   logic [SQ_W-1:0]           sq_ff;
   logic [SUM_W-1:0]          sum;
   logic [DIST_W-1:0]         acc_ff, acc_in;
   logic [DIST_W-1:0]         best_dist_ff;
   logic [COORD_W-1:0]        best_x_ff, best_y_ff;
   logic                      better;

   // Square of the difference; the product never goes negative
   assign prod = diff_ff * diff_ff;

   // Saturating accumulate, restarted on the first dimension of a node
   assign sum    = (tag3_ff.tag.first_dim ? '0 : SUM_W'(acc_ff)) + SUM_W'(sq_ff);
   assign acc_in = (sum > SUM_W'(DIST_MAX)) ? DIST_MAX : sum[DIST_W-1:0];

   // First node always wins; later ones only when strictly smaller
   assign better = node_tag_ff.first_node || (acc_ff < best_dist_ff);

   // Advance the stage valids
   always_ff @(posedge clock) begin
      if (reset) begin
         tag1_ff     <= '0;
         tag2_ff     <= '0;
         tag3_ff     <= '0;
         node_vld_ff <= 1'b0;
         done_ff     <= 1'b0;
      end else begin
         tag1_ff     <= issue;
         tag2_ff     <= tag1_ff;
         tag3_ff     <= tag2_ff;
         node_vld_ff <= tag3_ff.valid && tag3_ff.tag.last_dim;
         done_ff     <= node_vld_ff && node_tag_ff.last_node;
      end
   end

   // Datapath stages
   always_ff @(posedge clock) begin
      diff_ff <= DIFF_W'(cb_rdata) - DIFF_W'(fb_rdata);
      sq_ff   <= unsigned'(prod);
      if (tag3_ff.valid) begin
         acc_ff      <= acc_in;
         node_tag_ff <= tag3_ff.tag;
      end
      if (node_vld_ff && better) begin
         best_dist_ff <= acc_ff;
         best_x_ff    <= node_tag_ff.x;
         best_y_ff    <= node_tag_ff.y;
      end
   end

   assign result.done    = done_ff;
   assign result.x       = best_x_ff;
   assign result.y       = best_y_ff;
   assign result.dist_sq = best_dist_ff;

`ifndef NO_ASSERTIONS
   a_done_single: assert property (@(posedge clock) disable iff (reset)
      done_ff |=> !done_ff)
      else $error("winner strobe longer than one cycle");
`endif

endmodule

// File: rtl/core/som_best_matching_unit_search_top.sv
// ----------------------------------------------------------------------------
// som_best_matching_unit_search_top
// Best-matching-unit search of a self-organizing map, squared Euclidean.
// ----------------------------------------------------------------------------
// Usage:
//   req_bus carries one element per transfer. Action codebook writes the
//   element at (node_x, node_y, dim_index); action feature loads the feature
//   element at dim_index. A feature item with last_elem set stores its
//   element and starts a search over map_height rows and map_width columns
//   in use. The search runs through one shared subtract-square-accumulate
//   unit, one element per cycle. req_bus.ready is low while a search runs.
//   rsp_bus returns bmu_x, bmu_y and best_dist_sq from an output register.
//   When the receiver stalls the result holds; further items are still taken
//   and a following search holds its result until the register drains.
//   Reset sets map_width 16, map_height 16, vector_dims 32. The codebook
//   store and the feature buffer are not cleared and must be written first.
//   The user must write the registers over the APB port only while the
//   block is idle; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module som_best_matching_unit_search_top #(
   parameter int unsigned MAX_MAP_X  = 16,
   parameter int unsigned MAX_MAP_Y  = 16,
   parameter int unsigned MAX_DIMS   = 32,
   parameter int unsigned VALUE_BITS = 16
) (
   input  logic                            clock,
   input  logic                            reset,
   som_bmu_req_if.sink                     req_bus,
   som_bmu_rsp_if.source                   rsp_bus,
   input  logic                            psel,
   input  logic                            penable,
   input  logic                            pwrite,
   input  logic [som_bmu_pkg::CSR_AW-1:0]  paddr,
   input  logic [som_bmu_pkg::CSR_DW-1:0]  pwdata,
   output logic [som_bmu_pkg::CSR_DW-1:0]  prdata,
   output logic                            pready
);
   import som_bmu_pkg::*;

   localparam int unsigned CB_DEPTH = MAX_MAP_X * MAX_MAP_Y * MAX_DIMS;
   localparam int unsigned CB_AW    = (CB_DEPTH > 1) ? $clog2(CB_DEPTH) : 1;
   localparam int unsigned DW       = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;

   logic [MAP_REG_W-1:0]         map_width, map_height;
   logic [DIMS_REG_W-1:0]        vector_dims;
   logic                         accept, in_bounds, start;
   logic                         cb_we, fb_we;
   logic [CB_AW-1:0]             cb_waddr, cb_raddr;
   logic [DW-1:0]                fb_waddr, fb_raddr;
   logic [VALUE_BITS-1:0]        wdata;
   logic signed [VALUE_BITS-1:0] cb_rdata, fb_rdata;
   issue_type                    issue;
   seq_status_type               status;
   result_type                   result;
   logic                         rsp_free;
   logic                         rsp_valid_ff, rsp_valid_in;
   logic [NODE_W-1:0]            bmu_x_ff, bmu_y_ff;
   logic [DIST_W-1:0]            best_dist_ff;

   som_bmu_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .psel        (psel),
      .penable     (penable),
      .pwrite      (pwrite),
      .paddr       (paddr),
      .pwdata      (pwdata),
      .prdata      (prdata),
      .pready      (pready),
      .map_width   (map_width),
      .map_height  (map_height),
      .vector_dims (vector_dims)
   );

   // Decode the input transfer
   assign accept    = req_bus.valid & req_bus.ready;
   assign in_bounds = (32'(req_bus.node_x) < MAX_MAP_X) &&
                      (32'(req_bus.node_y) < MAX_MAP_Y) &&
                      (32'(req_bus.dim_index) < MAX_DIMS);
   assign cb_we     = accept && (req_bus.action == ACTION_CODEBOOK) && in_bounds;
   assign fb_we     = accept && (req_bus.action == ACTION_FEATURE) &&
                      (32'(req_bus.dim_index) < MAX_DIMS);
   assign start     = accept && (req_bus.action == ACTION_FEATURE) && req_bus.last_elem;
   assign cb_waddr  = CB_AW'((32'(req_bus.node_y) * MAX_MAP_X + 32'(req_bus.node_x))
                             * MAX_DIMS + 32'(req_bus.dim_index));
   assign fb_waddr  = DW'(req_bus.dim_index);

   // Fit the element to the stored value width, keeping its sign
   generate
      if (VALUE_BITS >= ELEM_W) begin : g_value_ext
         assign wdata = unsigned'(VALUE_BITS'(req_bus.elem_value));
      end else begin : g_value_trunc
         assign wdata = req_bus.elem_value[VALUE_BITS-1:0];
      end
   endgenerate

   som_bmu_mem #(
      .MAX_MAP_X  (MAX_MAP_X),
      .MAX_MAP_Y  (MAX_MAP_Y),
      .MAX_DIMS   (MAX_DIMS),
      .VALUE_BITS (VALUE_BITS)
   ) u_mem (
      .clock    (clock),
      .cb_we    (cb_we),
      .cb_waddr (cb_waddr),
      .fb_we    (fb_we),
      .fb_waddr (fb_waddr),
      .wdata    (wdata),
      .rd_en    (issue.valid),
      .cb_raddr (cb_raddr),
      .fb_raddr (fb_raddr),
      .cb_rdata (cb_rdata),
      .fb_rdata (fb_rdata)
   );

   som_bmu_seq #(
      .MAX_MAP_X (MAX_MAP_X),
      .MAX_MAP_Y (MAX_MAP_Y),
      .MAX_DIMS  (MAX_DIMS)
   ) u_seq (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .done        (result.done),
      .rsp_free    (rsp_free),
      .map_width   (map_width),
      .map_height  (map_height),
      .vector_dims (vector_dims),
      .issue       (issue),
      .cb_raddr    (cb_raddr),
      .fb_raddr    (fb_raddr),
      .status      (status)
   );

   som_bmu_dist #(
      .VALUE_BITS (VALUE_BITS)
   ) u_dist (
      .clock    (clock),
      .reset    (reset),
      .issue    (issue),
      .cb_rdata (cb_rdata),
      .fb_rdata (fb_rdata),
      .result   (result)
   );

   assign req_bus.ready = status.ready;

   // Result register: load the winner when the slot is free, drop on transfer
   assign rsp_free     = !rsp_valid_ff || rsp_bus.ready;
   assign rsp_valid_in = status.load || (rsp_valid_ff && !rsp_bus.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (status.load) begin
         bmu_x_ff     <= result.x[NODE_W-1:0];
         bmu_y_ff     <= result.y[NODE_W-1:0];
         best_dist_ff <= result.dist_sq;
      end
   end

   assign rsp_bus.valid        = rsp_valid_ff;
   assign rsp_bus.bmu_x        = bmu_x_ff;
   assign rsp_bus.bmu_y        = bmu_y_ff;
   assign rsp_bus.best_dist_sq = best_dist_ff;

`ifndef NO_ASSERTIONS
   a_no_accept_on_load: assert property (@(posedge clock) disable iff (reset)
      status.load |-> !accept)
      else $error("input transfer taken while a result is posted");
`endif

endmodule

// File: tb/sv/som_best_matching_unit_search_top_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// som_best_matching_unit_search_top_tb
// Self-checking bench for the SOM best-matching-unit search block. It loads
// codebook and feature elements over the request channel and tracks them in
// a local copy of the stores. On every last-marked feature element it scans
// the map in use for the nearest node by squared Euclidean distance, with
// the first node winning ties, and queues the winner. Each response transfer
// is checked against the oldest queued winner. Map and vector sizes change
// over the APB port between phases, out-of-range values included.
// ----------------------------------------------------------------------------
module som_best_matching_unit_search_top_tb;
   import som_bmu_pkg::*;

   localparam int unsigned MAP_X = 16;
   localparam int unsigned MAP_Y = 16;
   localparam int unsigned DIMS  = 32;
   localparam int unsigned CB_DEPTH = MAP_X * MAP_Y * DIMS;

   localparam int ITEM_TARGET    = 1800;
   localparam int WATCHDOG_LIMIT = 20000;
   localparam int SETTLE_CYCLES  = 12;
   localparam int END_CYCLES     = 300;

   localparam reg_index_type REG_UNUSED = 2'd3;

   typedef struct packed {
      logic [NODE_W-1:0] bmu_x;
      logic [NODE_W-1:0] bmu_y;
      logic [DIST_W-1:0] best_dist_sq;
   } bmu_result_type;

   logic clock = 1'b0;
   logic reset;
   logic psel;
   logic penable;
   logic pwrite;
   logic [CSR_AW-1:0] paddr;
   logic [CSR_DW-1:0] pwdata;
   logic [CSR_DW-1:0] prdata;
   logic pready;

   som_bmu_req_if req_bus ();
   som_bmu_rsp_if rsp_bus ();

   som_best_matching_unit_search_top #(
      .MAX_MAP_X (MAP_X),
      .MAX_MAP_Y (MAP_Y),
      .MAX_DIMS  (DIMS),
      .VALUE_BITS(16)
   ) u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_bus(req_bus),
      .rsp_bus(rsp_bus),
      .psel   (psel),
      .penable(penable),
      .pwrite (pwrite),
      .paddr  (paddr),
      .pwdata (pwdata),
      .prdata (prdata),
      .pready (pready)
   );

   always #6 clock = ~clock;

   // Local copy of the stores and registers
   logic signed [ELEM_W-1:0] cb_mem [CB_DEPTH];
   bit                       cb_written [CB_DEPTH];
   logic signed [ELEM_W-1:0] feat_mem [DIMS];
   bit                       feat_written [DIMS];
   logic [MAP_REG_W-1:0]     map_width_reg;
   logic [MAP_REG_W-1:0]     map_height_reg;
   logic [DIMS_REG_W-1:0]    vector_dims_reg;

   bmu_result_type pending_bmu_q [$];
   int             mismatch_count;
   int             req_transfers;
   bit             req_gaps_on;
   bit             rsp_stalls_on;

   function automatic int sat_count(int v, int hi);
      if (v < 1) begin
         return 1;
      end else if (v > hi) begin
         return hi;
      end
      return v;
   endfunction

   function automatic int cb_index(int x, int y, int d);
      return ((y * MAP_X) + x) * DIMS + d;
   endfunction

   function automatic int cur_width();
      return sat_count(int'(map_width_reg), MAP_X);
   endfunction

   function automatic int cur_height();
      return sat_count(int'(map_height_reg), MAP_Y);
   endfunction

   function automatic int cur_dims();
      return sat_count(int'(vector_dims_reg), DIMS);
   endfunction

   // Scan rows, then columns; a strictly smaller distance takes the lead
   function automatic bmu_result_type find_best_match();
      bmu_result_type   best;
      longint unsigned  sum_sq;
      longint           diff;
      bit               have;
      best = '0;
      have = 1'b0;
      for (int y = 0; y < cur_height(); y++) begin
         for (int x = 0; x < cur_width(); x++) begin
            sum_sq = 0;
            for (int d = 0; d < cur_dims(); d++) begin
               diff = longint'(cb_mem[cb_index(x, y, d)]) - longint'(feat_mem[d]);
               sum_sq += longint'(diff * diff);
            end
            if (sum_sq > longint'(DIST_MAX)) begin
               sum_sq = longint'(DIST_MAX);
            end
            if (!have || sum_sq < longint'(best.best_dist_sq)) begin
               have              = 1'b1;
               best.bmu_x        = x[NODE_W-1:0];
               best.bmu_y        = y[NODE_W-1:0];
               best.best_dist_sq = sum_sq[DIST_W-1:0];
            end
         end
      end
      return best;
   endfunction

   // Mostly short gaps, a few long ones
   function automatic int pick_gap(bit enable);
      int r;
      r = $urandom_range(0, 99);
      if (!enable || r < 60) begin
         return 0;
      end else if (r < 90) begin
         return $urandom_range(1, 3);
      end else if (r < 98) begin
         return $urandom_range(4, 12);
      end
      return $urandom_range(20, 60);
   endfunction

   // Bias toward the extremes and tiny values so that ties show up
   function automatic logic signed [ELEM_W-1:0] rand_elem();
      int r;
      r = $urandom_range(0, 9);
      case (r)
         0: begin
            return 16'sh8000;
         end
         1: begin
            return 16'sh7FFF;
         end
         2: begin
            return '0;
         end
         3, 4: begin
            return ELEM_W'($urandom_range(0, 4) - 2);
         end
         default: begin
            return ELEM_W'($urandom);
         end
      endcase
   endfunction

   task automatic report_mismatch(string msg);
      $display("[%0t] MISMATCH %s", $time, msg);
      mismatch_count++;
   endtask

   // Send one element and update the local stores once it is taken
   task automatic send_elem(logic action, int x, int y, int d,
                            logic signed [ELEM_W-1:0] value, bit is_last);
      int gap;
      gap = pick_gap(req_gaps_on);
      repeat (gap) begin
         @(negedge clock);
         req_bus.valid = 1'b0;
      end
      @(negedge clock);
      req_bus.valid      = 1'b1;
      req_bus.action     = action;
      req_bus.node_x     = x[NODE_W-1:0];
      req_bus.node_y     = y[NODE_W-1:0];
      req_bus.dim_index  = d[DIM_IDX_W-1:0];
      req_bus.elem_value = value;
      req_bus.last_elem  = is_last;
      do @(posedge clock); while (!req_bus.ready);
      req_transfers++;
      if (action == ACTION_CODEBOOK) begin
         cb_mem[cb_index(x, y, d)]     = value;
         cb_written[cb_index(x, y, d)] = 1'b1;
      end else begin
         feat_mem[d]     = value;
         feat_written[d] = 1'b1;
         if (is_last) begin
            pending_bmu_q = {pending_bmu_q, find_best_match()};
         end
      end
   endtask

   // Hold off the sender until every pending result has arrived
   task automatic wait_for_results();
      @(negedge clock);
      req_bus.valid = 1'b0;
      while (pending_bmu_q.size() != 0) begin
         @(posedge clock);
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(reg_index_type idx, logic [CSR_DW-1:0] data);
      @(negedge clock);
      psel    = 1'b1;
      penable = 1'b0;
      pwrite  = 1'b1;
      paddr   = {idx, 2'b00};
      pwdata  = data;
      @(negedge clock);
      penable = 1'b1;
      do @(posedge clock); while (!pready);
      case (idx)
         REG_MAP_WIDTH: begin
            map_width_reg = data[MAP_REG_W-1:0];
         end
         REG_MAP_HEIGHT: begin
            map_height_reg = data[MAP_REG_W-1:0];
         end
         REG_VECTOR_DIMS: begin
            vector_dims_reg = data[DIMS_REG_W-1:0];
         end
         default: begin
         end
      endcase
      @(negedge clock);
      psel    = 1'b0;
      penable = 1'b0;
      pwrite  = 1'b0;
   endtask

   // Change the map sizes while the block is idle
   task automatic set_map_config(int w_raw, int h_raw, int d_raw);
      wait_for_results();
      csr_write(REG_MAP_WIDTH, CSR_DW'(w_raw));
      csr_write(REG_MAP_HEIGHT, CSR_DW'(h_raw));
      csr_write(REG_VECTOR_DIMS, CSR_DW'(d_raw));
      csr_write(REG_UNUSED, $urandom);
   endtask

   // Write every codebook and feature entry in use that is still unknown
   task automatic fill_in_use();
      for (int y = 0; y < cur_height(); y++) begin
         for (int x = 0; x < cur_width(); x++) begin
            for (int d = 0; d < cur_dims(); d++) begin
               if (!cb_written[cb_index(x, y, d)]) begin
                  send_elem(ACTION_CODEBOOK, x, y, d, rand_elem(), $urandom_range(0, 1));
               end
            end
         end
      end
      for (int d = 0; d < cur_dims(); d++) begin
         if (!feat_written[d]) begin
            send_elem(ACTION_FEATURE, 0, 0, d, rand_elem(), 1'b0);
         end
      end
   endtask

   // Codebook updates and noise, then a feature vector ending in a search
   task automatic run_random_search();
      int n_cb;
      int x;
      int y;
      int d;
      int j;
      int tmp;
      int hit_x;
      int hit_y;
      bit exact_hit;
      int order [DIMS];
      logic signed [ELEM_W-1:0] value;
      n_cb = $urandom_range(0, 6);
      for (int i = 0; i < n_cb; i++) begin
         if ($urandom_range(0, 3) == 0) begin
            x = $urandom_range(0, MAP_X - 1);
            y = $urandom_range(0, MAP_Y - 1);
            d = $urandom_range(0, DIMS - 1);
         end else begin
            x = $urandom_range(0, cur_width() - 1);
            y = $urandom_range(0, cur_height() - 1);
            d = $urandom_range(0, cur_dims() - 1);
         end
         send_elem(ACTION_CODEBOOK, x, y, d, rand_elem(), $urandom_range(0, 1));
      end
      fill_in_use();
      if ($urandom_range(0, 9) < 7) begin
         // Full vector in shuffled order, sometimes a copy of one node
         for (int i = 0; i < cur_dims(); i++) begin
            order[i] = i;
         end
         for (int i = cur_dims() - 1; i > 0; i--) begin
            j        = $urandom_range(0, i);
            tmp      = order[i];
            order[i] = order[j];
            order[j] = tmp;
         end
         exact_hit = ($urandom_range(0, 2) == 0);
         hit_x     = $urandom_range(0, cur_width() - 1);
         hit_y     = $urandom_range(0, cur_height() - 1);
         for (int i = 0; i < cur_dims(); i++) begin
            value = exact_hit ? cb_mem[cb_index(hit_x, hit_y, order[i])] : rand_elem();
            send_elem(ACTION_FEATURE, $urandom_range(0, 15), $urandom_range(0, 15),
                      order[i], value, i == cur_dims() - 1);
         end
      end else begin
         // Partial update at any index, last mark anywhere
         n_cb = $urandom_range(0, 4);
         for (int i = 0; i < n_cb; i++) begin
            send_elem(ACTION_FEATURE, 0, 0, $urandom_range(0, DIMS - 1), rand_elem(), 1'b0);
         end
         send_elem(ACTION_FEATURE, 0, 0, $urandom_range(0, DIMS - 1), rand_elem(), 1'b1);
      end
   endtask

   // Value extremes, first-node tie, last mark on a codebook item
   task automatic test_directed_cases();
      req_gaps_on   = 1'b0;
      rsp_stalls_on = 1'b0;
      set_map_config(2, 2, 2);
      for (int d = 0; d < 2; d++) begin
         send_elem(ACTION_CODEBOOK, 0, 0, d, 16'sh7FFF, 1'b0);
         send_elem(ACTION_CODEBOOK, 1, 0, d, 16'sh8000, 1'b1);
         send_elem(ACTION_CODEBOOK, 0, 1, d, 16'sh0000, 1'b1);
         send_elem(ACTION_CODEBOOK, 1, 1, d, 16'sh0000, 1'b0);
      end
      send_elem(ACTION_FEATURE, 0, 0, 0, 16'sh0000, 1'b0);
      send_elem(ACTION_FEATURE, 0, 0, 1, 16'sh0000, 1'b1);
      send_elem(ACTION_FEATURE, 0, 0, 0, 16'sh8000, 1'b0);
      send_elem(ACTION_FEATURE, 0, 0, 1, 16'sh8000, 1'b1);
      send_elem(ACTION_FEATURE, 0, 0, 0, 16'sh7FFF, 1'b0);
      send_elem(ACTION_FEATURE, 0, 0, 1, 16'sh7FFF, 1'b1);
      send_elem(ACTION_FEATURE, 0, 0, 1, 16'sh8000, 1'b1);
      send_elem(ACTION_FEATURE, 0, 0, DIMS - 1, 16'sh1234, 1'b1);
      send_elem(ACTION_FEATURE, 15, 15, 0, 16'sh0001, 1'b1);
      wait_for_results();
   endtask

   // Register extremes, out-of-range values and an unused register index
   task automatic test_config_extremes();
      int w_raw [8] = '{1, 16, 1, 0, 31, 2, 16, 16};
      int h_raw [8] = '{1, 1, 16, 0, 1, 1, 16, 31};
      int d_raw [8] = '{1, 2, 2, 0, 0, 63, 1, 1};
      for (int i = 0; i < 8; i++) begin
         req_gaps_on   = (i % 2 == 0);
         rsp_stalls_on = (i % 3 != 0);
         set_map_config(w_raw[i], h_raw[i], d_raw[i]);
         fill_in_use();
         repeat (3) run_random_search();
      end
   endtask

   // Largest possible distance at full vector length, tied on both nodes
   task automatic test_max_distance();
      req_gaps_on   = 1'b1;
      rsp_stalls_on = 1'b1;
      set_map_config(2, 1, DIMS);
      for (int d = 0; d < DIMS; d++) begin
         send_elem(ACTION_CODEBOOK, 0, 0, d, 16'sh8000, 1'b0);
         send_elem(ACTION_CODEBOOK, 1, 0, d, 16'sh8000, 1'b0);
      end
      for (int d = 0; d < DIMS; d++) begin
         send_elem(ACTION_FEATURE, 0, 0, d, 16'sh7FFF, d == DIMS - 1);
      end
      set_map_config(1, 1, 63);
      repeat (2) run_random_search();
   endtask

   // Random phases with small maps until the item budget is spent
   task automatic test_random_traffic();
      int searches_left;
      int w_raw;
      int h_raw;
      int d_raw;
      searches_left = 0;
      while (req_transfers < ITEM_TARGET) begin
         if (searches_left == 0) begin
            do begin
               w_raw = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 31) : $urandom_range(1, 6);
               h_raw = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 31) : $urandom_range(1, 6);
               d_raw = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 63) : $urandom_range(1, 8);
            end while (sat_count(w_raw, MAP_X) * sat_count(h_raw, MAP_Y) *
                       sat_count(d_raw, DIMS) > 256);
            set_map_config(w_raw, h_raw, d_raw);
            req_gaps_on   = ($urandom_range(0, 3) != 0);
            rsp_stalls_on = ($urandom_range(0, 3) != 0);
            fill_in_use();
            searches_left = $urandom_range(3, 10);
         end
         run_random_search();
         searches_left--;
         if ($urandom_range(0, 15) == 0) begin
            wait_for_results();
         end
      end
   endtask

   // Compare each response transfer with the oldest pending winner
   always @(posedge clock) begin
      bmu_result_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (pending_bmu_q.size() == 0) begin
            report_mismatch($sformatf("result with none pending: x %0d y %0d dist %0d",
                                      rsp_bus.bmu_x, rsp_bus.bmu_y, rsp_bus.best_dist_sq));
         end else begin
            want = pending_bmu_q.pop_front();
            if (rsp_bus.bmu_x !== want.bmu_x) begin
               report_mismatch($sformatf("bmu_x got %0d expected %0d",
                                         rsp_bus.bmu_x, want.bmu_x));
            end
            if (rsp_bus.bmu_y !== want.bmu_y) begin
               report_mismatch($sformatf("bmu_y got %0d expected %0d",
                                         rsp_bus.bmu_y, want.bmu_y));
            end
            if (rsp_bus.best_dist_sq !== want.best_dist_sq) begin
               report_mismatch($sformatf("best_dist_sq got %0d expected %0d",
                                         rsp_bus.best_dist_sq, want.best_dist_sq));
            end
         end
      end
   end

   // Drive response ready with random stalls
   initial begin
      int stall;
      stall         = 0;
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (stall > 0) begin
            rsp_bus.ready = 1'b0;
            stall--;
         end else begin
            stall         = pick_gap(rsp_stalls_on);
            rsp_bus.ready = (stall == 0);
            if (stall > 0) begin
               stall--;
            end
         end
      end
   end

   // End the run when no transfer happens for too long
   initial begin
      int idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
            idle_cycles = 0;
         end else begin
            idle_cycles++;
         end
      end
      $display("RESULT: ERROR");
      $finish;
   end

   initial begin
      reset              = 1'b1;
      psel               = 1'b0;
      penable            = 1'b0;
      pwrite             = 1'b0;
      paddr              = '0;
      pwdata             = '0;
      req_bus.valid      = 1'b0;
      req_bus.action     = ACTION_CODEBOOK;
      req_bus.node_x     = '0;
      req_bus.node_y     = '0;
      req_bus.dim_index  = '0;
      req_bus.elem_value = '0;
      req_bus.last_elem  = 1'b0;
      map_width_reg      = RESET_MAP_WIDTH;
      map_height_reg     = RESET_MAP_HEIGHT;
      vector_dims_reg    = RESET_VECTOR_DIMS;
      mismatch_count     = 0;
      req_transfers      = 0;
      req_gaps_on        = 1'b0;
      rsp_stalls_on      = 1'b0;
      for (int i = 0; i < CB_DEPTH; i++) begin
         cb_mem[i]     = '0;
         cb_written[i] = 1'b0;
      end
      for (int i = 0; i < DIMS; i++) begin
         feat_mem[i]     = '0;
         feat_written[i] = 1'b0;
      end
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_directed_cases();
      test_config_extremes();
      test_max_distance();
      test_random_traffic();

      // Drain, then let the pipeline settle before the verdict
      wait_for_results();
      repeat (END_CYCLES) @(posedge clock);
      if (pending_bmu_q.size() != 0) begin
         report_mismatch($sformatf("%0d results never arrived", pending_bmu_q.size()));
      end
      if (mismatch_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
